/* src/sda_pkg.sv */
// sda_pkg: shared types, codes and helper functions for the swr dip auto-tune sequencer
// no dependencies; imported by sda_cfg_regs, sda_step, the top level and sda_checker

package sda_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_THRESH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_THRESH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_DELTA = 2'd3;

  // reset values of the configuration registers
  localparam logic [15:0] RST_BACKOFF_TIME = 16'd1000;
  localparam logic [15:0] RST_FAST_THRESH  = 16'd768;
  localparam logic [15:0] RST_SLOW_THRESH  = 16'd384;
  localparam logic [15:0] RST_SETTLE_DELTA = 16'd13;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  // motor and run direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // motor speed codes
  localparam logic [1:0] SPD_IDLE = 2'd0;
  localparam logic [1:0] SPD_FAST = 2'd1;
  localparam logic [1:0] SPD_SLOW = 2'd2;
  localparam logic [1:0] SPD_FINE = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_BACKOFF   = 3'd1,
    ST_FAST      = 3'd2,
    ST_FAST_WAIT = 3'd3,
    ST_SLOW      = 3'd4,
    ST_SLOW_WAIT = 3'd5,
    ST_FINE      = 3'd6
  } fsm_state_t;

  typedef struct packed {
    logic [15:0] backoff_time_ms;
    logic [15:0] fast_swr_threshold;
    logic [15:0] slow_swr_threshold;
    logic [15:0] settle_swr_delta;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        tune_dir;
    logic [15:0] forward_power;
    logic [15:0] swr_sample;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0] tune_state;
    logic [1:0] motor_dir;
    logic [1:0] motor_speed;
    logic       stop_issued;
    logic [1:0] run_dir;
  } result_t;

  function automatic logic [1:0] motor_dir_for(fsm_state_t st, logic [1:0] rd);
    logic [1:0] with_dir;
    logic [1:0] against_dir;
    logic [1:0] res;
    with_dir    = (rd == DIR_DOWN) ? DIR_DOWN : DIR_UP;
    against_dir = (rd == DIR_DOWN) ? DIR_UP : DIR_DOWN;
    case (st)
      ST_FAST, ST_FINE:    res = with_dir;
      ST_BACKOFF, ST_SLOW: res = against_dir;
      default:             res = DIR_NONE;
    endcase
    return res;
  endfunction

  function automatic logic [1:0] motor_speed_for(fsm_state_t st);
    logic [1:0] res;
    case (st)
      ST_BACKOFF, ST_FAST: res = SPD_FAST;
      ST_SLOW:             res = SPD_SLOW;
      ST_FINE:             res = SPD_FINE;
      default:             res = SPD_IDLE;
    endcase
    return res;
  endfunction

  function automatic fsm_state_t next_state(fsm_state_t st);
    fsm_state_t res;
    case (st)
      ST_BACKOFF:   res = ST_FAST;
      ST_FAST:      res = ST_FAST_WAIT;
      ST_FAST_WAIT: res = ST_SLOW;
      ST_SLOW:      res = ST_SLOW_WAIT;
      ST_SLOW_WAIT: res = ST_FINE;
      default:      res = ST_IDLE;
    endcase
    return res;
  endfunction

endpackage

/* src/sda_if.sv */
// sda_in_if / sda_out_if: valid-ready channels for sample transactions and results
// depends on nothing; the top level uses a sink of the first and a source of the second

interface sda_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        tune_dir;
  logic [15:0] forward_power;
  logic [15:0] swr_sample;
  logic [31:0] now_ms;

  modport source (output valid, cmd, tune_dir, forward_power, swr_sample, now_ms,
                  input ready);
  modport sink   (input valid, cmd, tune_dir, forward_power, swr_sample, now_ms,
                  output ready);
endinterface

interface sda_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] tune_state;
  logic [1:0] motor_dir;
  logic [1:0] motor_speed;
  logic       stop_issued;
  logic [1:0] run_dir;

  modport source (output valid, tune_state, motor_dir, motor_speed, stop_issued, run_dir,
                  input ready);
  modport sink   (input valid, tune_state, motor_dir, motor_speed, stop_issued, run_dir,
                  output ready);
endinterface

/* src/sda_cfg_regs.sv */
// sda_cfg_regs: configuration register file written through the plain write port
// depends on sda_pkg

module sda_cfg_regs
  import sda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.backoff_time_ms    <= RST_BACKOFF_TIME;
      cfg.fast_swr_threshold <= RST_FAST_THRESH;
      cfg.slow_swr_threshold <= RST_SLOW_THRESH;
      cfg.settle_swr_delta   <= RST_SETTLE_DELTA;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BACKOFF_TIME: cfg.backoff_time_ms    <= cfg_wdata;
        CFG_FAST_THRESH:  cfg.fast_swr_threshold <= cfg_wdata;
        CFG_SLOW_THRESH:  cfg.slow_swr_threshold <= cfg_wdata;
        CFG_SETTLE_DELTA: cfg.settle_swr_delta   <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

/* src/sda_step.sv */
// sda_step: sequencer state registers and the single-pass update for one transaction
// depends on sda_pkg; fed from the input register of the top level

module sda_step
  import sda_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  fsm_state_t  state, state_next;
  logic [1:0]  run_direction, run_direction_next;
  logic [31:0] backoff_start, backoff_start_next;
  logic        backoff_started, backoff_started_next;
  logic [15:0] best_swr, best_swr_next;
  logic        best_valid, best_valid_next;

  logic        stop;
  logic [31:0] start_eff;
  logic [31:0] elapsed;
  logic [15:0] thr;
  logic        rec_min;
  logic [15:0] swr_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      run_direction   <= DIR_NONE;
      backoff_started <= 1'b0;
      best_valid      <= 1'b0;
    end else if (fire) begin
      state           <= state_next;
      run_direction   <= run_direction_next;
      backoff_started <= backoff_started_next;
      best_valid      <= best_valid_next;
    end
  end

  // only read while the matching flag is set
  always_ff @(posedge clk) begin
    if (fire) begin
      backoff_start <= backoff_start_next;
      best_swr      <= best_swr_next;
    end
  end

  always_comb begin
    state_next           = state;
    run_direction_next   = run_direction;
    backoff_start_next   = backoff_start;
    backoff_started_next = backoff_started;
    best_swr_next        = best_swr;
    best_valid_next      = best_valid;
    stop                 = 1'b0;

    // first back-off tick latches its own time, so elapsed is zero then
    start_eff = backoff_started ? backoff_start : item.now_ms;
    elapsed   = item.now_ms - start_eff;
    thr       = (state == ST_FAST) ? cfg.fast_swr_threshold : cfg.slow_swr_threshold;
    rec_min   = (item.swr_sample <= thr) && (!best_valid || item.swr_sample <= best_swr);
    swr_diff  = (best_swr > item.swr_sample) ? best_swr - item.swr_sample
                                             : item.swr_sample - best_swr;

    case (item.cmd)
      CMD_BEGIN: begin
        backoff_started_next = 1'b0;
        state_next           = ST_BACKOFF;
        run_direction_next   = item.tune_dir ? DIR_DOWN : DIR_UP;
        best_valid_next      = 1'b0;
      end
      CMD_END: begin
        stop               = 1'b1;
        state_next         = ST_IDLE;
        run_direction_next = DIR_NONE;
      end
      CMD_TICK: begin
        if (state != ST_IDLE && item.forward_power == 16'd0) begin
          // lost rf aborts like an end command
          stop               = 1'b1;
          state_next         = ST_IDLE;
          run_direction_next = DIR_NONE;
        end else begin
          case (state)
            ST_BACKOFF: begin
              backoff_start_next   = start_eff;
              backoff_started_next = 1'b1;
              if (elapsed >= {16'd0, cfg.backoff_time_ms}) begin
                stop                 = 1'b1;
                state_next           = ST_FAST;
                best_valid_next      = 1'b0;
                backoff_started_next = 1'b0;
              end
            end
            ST_FAST, ST_SLOW, ST_FINE: begin
              if (rec_min) begin
                best_swr_next   = item.swr_sample;
                best_valid_next = 1'b1;
              end
              // a new minimum never counts as a rise
              if (best_valid && !rec_min && item.swr_sample > best_swr) begin
                stop                 = 1'b1;
                state_next           = next_state(state);
                best_valid_next      = 1'b0;
                backoff_started_next = 1'b0;
              end
            end
            ST_FAST_WAIT, ST_SLOW_WAIT: begin
              if (best_valid && swr_diff <= cfg.settle_swr_delta) begin
                state_next = next_state(state);
              end
              best_swr_next   = item.swr_sample;
              best_valid_next = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    res.tune_state  = state_next;
    res.motor_dir   = stop ? DIR_NONE : motor_dir_for(state_next, run_direction_next);
    res.motor_speed = stop ? SPD_IDLE : motor_speed_for(state_next);
    res.stop_issued = stop;
    res.run_dir     = run_direction_next;
  end

endmodule

/* src/swr_dip_autotune_fsm.sv */
// swr dip auto-tune sequencer: an accepted sample transaction reaches its result on out_ch
// through the input register, then the single-pass update into the result register
// throughput 1 transaction per cycle; the input register advances whenever the result
// register is empty or being taken, so in_ch stalls only while both registers are full
// synchronous active-high reset: sequencer idle, no run direction, no minimum recorded,
// configuration registers back to their defaults, both pipeline registers empty
module swr_dip_autotune_fsm
  import sda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  sda_in_if.sink                in_ch,
  sda_out_if.source             out_ch
);

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  logic    s1_adv;
  result_t step_res;
  result_t out_res;
  logic    out_valid;

  sda_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign s1_adv      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item.cmd           <= in_ch.cmd;
      s1_item.tune_dir      <= in_ch.tune_dir;
      s1_item.forward_power <= in_ch.forward_power;
      s1_item.swr_sample    <= in_ch.swr_sample;
      s1_item.now_ms        <= in_ch.now_ms;
    end
  end

  sda_step u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_adv),
    .item (s1_item),
    .cfg  (cfg),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= step_res;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.tune_state  = out_res.tune_state;
  assign out_ch.motor_dir   = out_res.motor_dir;
  assign out_ch.motor_speed = out_res.motor_speed;
  assign out_ch.stop_issued = out_res.stop_issued;
  assign out_ch.run_dir     = out_res.run_dir;

endmodule

/* src/sda_checker.sv */
// sda_checker: port-level assertions on the auto-tune sequencer, bound to the top level
// depends on sda_pkg; the bind below connects it to the out_ch signals of the top level

module sda_checker
  import sda_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] tune_state,
  input logic [1:0] motor_dir,
  input logic [1:0] motor_speed,
  input logic       stop_issued,
  input logic [1:0] run_dir
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tune_state) && $stable(motor_dir)
      && $stable(motor_speed) && $stable(stop_issued) && $stable(run_dir))
    else $error("result changed while stalled");

  // a force-stop always leaves the motor idle
  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && stop_issued |-> motor_dir == DIR_NONE && motor_speed == SPD_IDLE)
    else $error("motor driven on a stop transaction");

  // idle and the wait states never drive the motor
  a_quiet_states: assert property (@(posedge clk) disable iff (rst)
    out_valid && (tune_state == ST_IDLE || tune_state == ST_FAST_WAIT
      || tune_state == ST_SLOW_WAIT) |-> motor_dir == DIR_NONE && motor_speed == SPD_IDLE)
    else $error("motor driven while idle or waiting");

  // without a run direction the sequencer must be idle
  a_no_dir_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_dir == DIR_NONE |-> tune_state == ST_IDLE)
    else $error("active state with no run direction");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind swr_dip_autotune_fsm sda_checker u_sda_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .tune_state  (out_ch.tune_state),
  .motor_dir   (out_ch.motor_dir),
  .motor_speed (out_ch.motor_speed),
  .stop_issued (out_ch.stop_issued),
  .run_dir     (out_ch.run_dir)
);
